### design/rssi_fingerprint_nearest_match_top_defines.svh
// Assertion macros shared by the fingerprint matcher modules.
`ifndef RSSI_FINGERPRINT_NEAREST_MATCH_TOP_DEFINES_SVH
`define RSSI_FINGERPRINT_NEAREST_MATCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property at every rising edge outside reset.
`define RFNM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// Check a property at every rising edge, reset included.
`define RFNM_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`else

`define RFNM_ASSERT(label, clk, rst, prop)
`define RFNM_ASSERT_NORST(label, clk, prop)

`endif

`endif

### design/rfnm_pkg.sv
package rfnm_pkg;

  localparam int ADDR_W  = 48;
  localparam int LVL_W   = 8;
  localparam int COORD_W = 16;
  localparam int IDX_W   = 10;
  localparam int SLOT_FW = 4;
  localparam int DIM_W   = 5;
  localparam int CNT_W   = 11;
  localparam int CFG_W   = 11;

  localparam int DIM_RESET = 16;
  localparam int CNT_RESET = 1;

  // penalty for an address seen in only one of the two references
  localparam int PENALTY_OFFSET = 255;
  localparam int SQ_W           = 16;
  localparam int PEN_W          = 9;
  localparam int PEN_SQ_W       = 18;
  localparam int PEN_SQ_MAX     = 145924;

  typedef enum logic [1:0] {
    ACT_REF_SLOT   = 2'd0,
    ACT_REF_COORD  = 2'd1,
    ACT_QUERY_SLOT = 2'd2,
    ACT_CLASSIFY   = 2'd3
  } action_t;

  typedef enum logic {
    CFG_DIM   = 1'b0,
    CFG_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    action_t                    action;
    logic [IDX_W-1:0]           ref_index;
    logic [SLOT_FW-1:0]         slot;
    logic [ADDR_W-1:0]          ap_address;
    logic signed [LVL_W-1:0]    level_dbm;
    logic [COORD_W-1:0]         coord_x;
    logic [COORD_W-1:0]         coord_y;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] loc_x;
    logic [COORD_W-1:0] loc_y;
    logic [IDX_W-1:0]   winner_index;
  } res_t;

  typedef struct packed {
    logic [ADDR_W-1:0] ap_address;
    logic [LVL_W-1:0]  level;
  } slot_t;

  typedef struct packed {
    logic valid;
    logic first_j;
    logic last_j;
    logic last_pair;
  } scan_tag_t;

  typedef struct packed {
    logic done;
    logic chal_better;
  } score_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_FETCH,
    ST_POST
  } state_t;

endpackage

### design/rfnm_stream_if.sv
interface rfnm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/rfnm_ref_store.sv
module rfnm_ref_store #(
  parameter int DEPTH = 16384,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  rfnm_pkg::slot_t wdata,
  input  logic [AW-1:0]   raddr_a,
  input  logic [AW-1:0]   raddr_b,
  output rfnm_pkg::slot_t rdata_a,
  output rfnm_pkg::slot_t rdata_b
);
  import rfnm_pkg::*;

  slot_t mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### design/rfnm_aux_store.sv
module rfnm_aux_store #(
  parameter int SLOTS = 16,
  parameter int REFS  = 1024,
  parameter int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int RW    = $clog2(REFS)
) (
  input  logic                            clk,
  input  logic                            q_we,
  input  logic [SW-1:0]                   q_waddr,
  input  rfnm_pkg::slot_t                 q_wdata,
  input  logic [SW-1:0]                   q_raddr,
  output rfnm_pkg::slot_t                 q_rdata,
  input  logic                            c_we,
  input  logic [RW-1:0]                   c_waddr,
  input  logic [2*rfnm_pkg::COORD_W-1:0]  c_wdata,
  input  logic                            c_re,
  input  logic [RW-1:0]                   c_raddr,
  output logic [2*rfnm_pkg::COORD_W-1:0]  c_rdata
);
  import rfnm_pkg::*;

  slot_t                  qmem [SLOTS];
  logic [2*COORD_W-1:0]   cmem [REFS];

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_waddr] <= q_wdata;
    end
    q_rdata <= qmem[q_raddr];
  end

  // hold the coordinate read until the next fetch
  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_waddr] <= c_wdata;
    end
    if (c_re) begin
      c_rdata <= cmem[c_raddr];
    end
  end

endmodule

### design/rfnm_score.sv
`include "rssi_fingerprint_nearest_match_top_defines.svh"

module rfnm_score #(
  parameter int MAX_SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  rfnm_pkg::scan_tag_t  tag,
  input  rfnm_pkg::slot_t      query,
  input  rfnm_pkg::slot_t      best_slot,
  input  rfnm_pkg::slot_t      chal_slot,
  output rfnm_pkg::score_res_t result
);
  import rfnm_pkg::*;

  localparam int SUM_W = $clog2(MAX_SLOTS * PEN_SQ_MAX + 1);

  // stage B: read data arrive, search for the first matching slot
  scan_tag_t           tag_b;
  logic                fb, fc;
  logic [LVL_W-1:0]    lb, lc;
  logic                fb_prev, fc_prev, fb_now, fc_now;
  logic [LVL_W-1:0]    lb_now, lc_now;

  // stage C: one query slot finished
  logic                c_valid, c_last, c_fb, c_fc;
  logic [LVL_W-1:0]    c_ql, c_lb, c_lc;

  // stage D: squared terms
  logic signed [LVL_W:0] diff_b, diff_c;
  logic [LVL_W-1:0]      mag_b, mag_c;
  logic [PEN_W:0]        pen;
  logic [SQ_W-1:0]       sq_b, sq_c;
  logic [PEN_SQ_W-1:0]   sq_p, add_b, add_c;
  logic                  d_valid, d_last;
  logic [PEN_SQ_W-1:0]   d_add_b, d_add_c;

  // stage E: running sums
  logic [SUM_W-1:0]      sum_b, sum_c;
  logic                  done;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_b <= '0;
    end else begin
      tag_b <= tag;
    end
  end

  always_comb begin
    fb_prev = tag_b.first_j ? 1'b0 : fb;
    fc_prev = tag_b.first_j ? 1'b0 : fc;
    fb_now  = fb_prev || (best_slot.ap_address == query.ap_address);
    fc_now  = fc_prev || (chal_slot.ap_address == query.ap_address);
    lb_now  = fb_prev ? lb : best_slot.level;
    lc_now  = fc_prev ? lc : chal_slot.level;
  end

  always_ff @(posedge clk) begin
    if (tag_b.valid) begin
      fb <= fb_now;
      fc <= fc_now;
      lb <= lb_now;
      lc <= lc_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= tag_b.valid && tag_b.last_j;
    end
    c_last <= tag_b.last_pair;
    c_fb   <= fb_now;
    c_fc   <= fc_now;
    c_lb   <= lb_now;
    c_lc   <= lc_now;
    c_ql   <= query.level;
  end

  always_comb begin
    diff_b = $signed({c_ql[LVL_W-1], c_ql}) - $signed({c_lb[LVL_W-1], c_lb});
    diff_c = $signed({c_ql[LVL_W-1], c_ql}) - $signed({c_lc[LVL_W-1], c_lc});
    mag_b  = diff_b[LVL_W] ? LVL_W'(-diff_b) : diff_b[LVL_W-1:0];
    mag_c  = diff_c[LVL_W] ? LVL_W'(-diff_c) : diff_c[LVL_W-1:0];
    pen    = (PEN_W+1)'({{2{c_ql[LVL_W-1]}}, c_ql}) + (PEN_W+1)'(PENALTY_OFFSET);
    sq_b   = SQ_W'(mag_b) * SQ_W'(mag_b);
    sq_c   = SQ_W'(mag_c) * SQ_W'(mag_c);
    sq_p   = PEN_SQ_W'(pen[PEN_W-1:0]) * PEN_SQ_W'(pen[PEN_W-1:0]);
    add_b  = c_fb ? PEN_SQ_W'(sq_b) : (c_fc ? sq_p : '0);
    add_c  = c_fc ? PEN_SQ_W'(sq_c) : (c_fb ? sq_p : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
    d_last  <= c_last;
    d_add_b <= add_b;
    d_add_c <= add_c;
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      sum_b <= '0;
      sum_c <= '0;
    end else if (d_valid) begin
      sum_b <= sum_b + SUM_W'(d_add_b);
      sum_c <= sum_c + SUM_W'(d_add_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_valid && d_last;
    end
  end

  assign result.done        = done;
  assign result.chal_better = sum_c < sum_b;

  `RFNM_ASSERT(a_done_single, clk, rst, result.done |=> !result.done)
  `RFNM_ASSERT(a_last_gives_done, clk, rst, (d_valid && d_last) |=> result.done)

endmodule

### design/rssi_fingerprint_nearest_match_top.sv
// Nearest-neighbour location matcher over stored signal fingerprints. Load
// beats (reference slot, reference coordinates, query slot) are taken one per
// cycle while no classify is in progress. A classify beat runs a tournament:
// reference 0 starts as best and each later reference up to ref_count-1
// challenges it; per challenger the block walks every (query slot, reference
// slot) pair of the active dimension, one pair a cycle, reading best and
// challenger slots through the two read ports of the reference slot memory,
// then waits for the scoring pipeline to drain before the next challenger may
// use the updated best. The dimension and ref_count saturate to MAX_SLOTS
// and MAX_REFS. The command channel is held off until the classify finishes;
// the result sits in an output register, so load beats are taken again while
// it waits to be collected. A classify that finishes while the previous
// result still waits there holds, and holds the command channel with it,
// until that beat is collected. Stores are not cleared by reset: classify
// only over entries that were written.
`include "rssi_fingerprint_nearest_match_top_defines.svh"

module rssi_fingerprint_nearest_match_top #(
  parameter int MAX_SLOTS = 16,
  parameter int MAX_REFS  = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  rfnm_stream_if.sink                  cmd,
  rfnm_stream_if.source                res,
  input  logic                         cfg_we,
  input  rfnm_pkg::cfg_reg_t           cfg_index,
  input  logic [rfnm_pkg::CFG_W-1:0]   cfg_data
);
  import rfnm_pkg::*;

  localparam int SW       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int DW       = $clog2(MAX_SLOTS + 1);
  localparam int RW       = $clog2(MAX_REFS);
  localparam int NW       = $clog2(MAX_REFS + 1);
  localparam int RA_DEPTH = MAX_REFS * MAX_SLOTS;
  localparam int RAW      = $clog2(RA_DEPTH);

  // configuration
  logic [DIM_W-1:0] dim_cfg;
  logic [CNT_W-1:0] cnt_cfg;
  logic [DW-1:0]    dim_eff;
  logic [NW-1:0]    cnt_eff;
  logic             trivial;

  // sequencer
  state_t           state, state_next;
  logic             accept, is_classify;
  logic [SW-1:0]    qi, rj, dim_m1;
  logic [RW-1:0]    chal, best, last_c;
  logic [RAW-1:0]   chal_base, best_base;
  logic             last_j, last_pair, chal_last;

  // sequencer outputs
  logic             in_ready, sum_clear, coord_re, out_load;
  scan_tag_t        tag;

  // store ports
  logic             ref_we, coord_we, query_we;
  logic [RAW-1:0]   ref_waddr;
  slot_t            wslot, best_slot, chal_slot, query_slot;
  logic [2*COORD_W-1:0] coord_rdata;
  score_res_t       sc_res;

  // result register
  logic             out_valid;
  res_t             out_data;

  // ---------------------------------------------------------------------
  // Configuration registers; saturate the working values to the store size.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_cfg <= DIM_W'(DIM_RESET);
      cnt_cfg <= CNT_W'(CNT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIM:   dim_cfg <= cfg_data[DIM_W-1:0];
        CFG_COUNT: cnt_cfg <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_comb begin
    dim_eff = (32'(dim_cfg) > 32'(MAX_SLOTS)) ? DW'(MAX_SLOTS) : DW'(dim_cfg);
    cnt_eff = (32'(cnt_cfg) > 32'(MAX_REFS))  ? NW'(MAX_REFS)  : NW'(cnt_cfg);
    trivial = (cnt_eff < NW'(2)) || (dim_eff == '0);
  end

  // ---------------------------------------------------------------------
  // Load beats go straight into the stores; out-of-range writes drop.
  // ---------------------------------------------------------------------
  assign accept      = cmd.valid && cmd.ready;
  assign is_classify = cmd.data.action == ACT_CLASSIFY;

  always_comb begin
    ref_we   = accept && (cmd.data.action == ACT_REF_SLOT)
               && (32'(cmd.data.ref_index) < 32'(MAX_REFS))
               && (32'(cmd.data.slot) < 32'(MAX_SLOTS));
    coord_we = accept && (cmd.data.action == ACT_REF_COORD)
               && (32'(cmd.data.ref_index) < 32'(MAX_REFS));
    query_we = accept && (cmd.data.action == ACT_QUERY_SLOT)
               && (32'(cmd.data.slot) < 32'(MAX_SLOTS));
    ref_waddr = RAW'(32'(cmd.data.ref_index) * 32'(MAX_SLOTS) + 32'(cmd.data.slot));
    wslot.ap_address = cmd.data.ap_address;
    wslot.level      = cmd.data.level_dbm;
  end

  // ---------------------------------------------------------------------
  // Sequencer: walk slot pairs, wait for the score, advance the challenger.
  // ---------------------------------------------------------------------
  assign last_j    = rj == dim_m1;
  assign last_pair = last_j && (qi == dim_m1);
  assign chal_last = chal == last_c;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_classify) begin
          state_next = trivial ? ST_FETCH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_pair) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sc_res.done) begin
          state_next = chal_last ? ST_FETCH : ST_SCAN;
        end
      end
      ST_FETCH: state_next = ST_POST;
      ST_POST: begin
        if (!out_valid || res.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    sum_clear     = 1'b0;
    coord_re      = 1'b0;
    out_load      = 1'b0;
    tag.valid     = 1'b0;
    tag.first_j   = rj == '0;
    tag.last_j    = last_j;
    tag.last_pair = last_pair;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        sum_clear = accept && is_classify;
      end
      ST_SCAN:  tag.valid = 1'b1;
      ST_WAIT:  sum_clear = sc_res.done && !chal_last;
      ST_FETCH: coord_re = 1'b1;
      ST_POST:  out_load = !out_valid || res.ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best      <= '0;
      chal      <= RW'(1);
      best_base <= '0;
      chal_base <= RAW'(MAX_SLOTS);
      qi        <= '0;
      rj        <= '0;
      dim_m1    <= '0;
      last_c    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && is_classify) begin
            best      <= '0;
            chal      <= RW'(1);
            best_base <= '0;
            chal_base <= RAW'(MAX_SLOTS);
            qi        <= '0;
            rj        <= '0;
            dim_m1    <= SW'(dim_eff - DW'(1));
            last_c    <= RW'(cnt_eff - NW'(1));
          end
        end
        ST_SCAN: begin
          if (last_pair) begin
            qi <= '0;
            rj <= '0;
          end else if (last_j) begin
            qi <= qi + SW'(1);
            rj <= '0;
          end else begin
            rj <= rj + SW'(1);
          end
        end
        ST_WAIT: begin
          if (sc_res.done) begin
            // challenger takes over only on a strictly smaller sum
            if (sc_res.chal_better) begin
              best      <= chal;
              best_base <= chal_base;
            end
            if (!chal_last) begin
              chal      <= chal + RW'(1);
              chal_base <= chal_base + RAW'(MAX_SLOTS);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stores and scoring pipeline
  // ---------------------------------------------------------------------
  rfnm_ref_store #(
    .DEPTH (RA_DEPTH),
    .AW    (RAW)
  ) u_ref_store (
    .clk     (clk),
    .we      (ref_we),
    .waddr   (ref_waddr),
    .wdata   (wslot),
    .raddr_a (best_base + RAW'(rj)),
    .raddr_b (chal_base + RAW'(rj)),
    .rdata_a (best_slot),
    .rdata_b (chal_slot)
  );

  rfnm_aux_store #(
    .SLOTS (MAX_SLOTS),
    .REFS  (MAX_REFS),
    .SW    (SW),
    .RW    (RW)
  ) u_aux_store (
    .clk     (clk),
    .q_we    (query_we),
    .q_waddr (SW'(cmd.data.slot)),
    .q_wdata (wslot),
    .q_raddr (qi),
    .q_rdata (query_slot),
    .c_we    (coord_we),
    .c_waddr (RW'(cmd.data.ref_index)),
    .c_wdata ({cmd.data.coord_x, cmd.data.coord_y}),
    .c_re    (coord_re),
    .c_raddr (best),
    .c_rdata (coord_rdata)
  );

  rfnm_score #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_score (
    .clk       (clk),
    .rst       (rst),
    .clear     (sum_clear),
    .tag       (tag),
    .query     (query_slot),
    .best_slot (best_slot),
    .chal_slot (chal_slot),
    .result    (sc_res)
  );

  // ---------------------------------------------------------------------
  // Result register: hold the beat until the sink takes it.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.loc_x        <= coord_rdata[2*COORD_W-1:COORD_W];
      out_data.loc_y        <= coord_rdata[COORD_W-1:0];
      out_data.winner_index <= IDX_W'(best);
    end
  end

  assign cmd.ready = in_ready;
  assign res.valid = out_valid;
  assign res.data  = out_data;

  `RFNM_ASSERT(a_classify_blocks, clk, rst, (accept && is_classify) |=> !cmd.ready)
  `RFNM_ASSERT(a_best_not_ahead, clk, rst, (state == ST_SCAN || state == ST_WAIT) |-> best <= chal)
  `RFNM_ASSERT(a_score_in_wait, clk, rst, sc_res.done |-> state == ST_WAIT)
  `RFNM_ASSERT_NORST(a_reset_empty, clk, rst |=> !res.valid)

endmodule
